>>> rtl/nsks_pkg.sv
// shared types, codes and widths for the nesting stack with kind search
`timescale 1ns / 1ps

package nsks_pkg;

  localparam int OP_W     = 3;
  localparam int KIND_W   = 4;
  localparam int MODE_W   = 2;
  localparam int OCC_W    = 5;
  localparam int CLAUSE_W = 8;
  localparam int NAME_W   = 16;
  localparam int LINE_W   = 24;
  localparam int FILE_W   = 16;
  localparam int LEVEL_W  = 4;
  localparam int ERR_W    = 3;
  localparam int INDEX_W  = 4;
  localparam int COUNT_W  = 5;

  localparam logic [OP_W-1:0] OP_PUSH    = 3'd0;
  localparam logic [OP_W-1:0] OP_POP     = 3'd1;
  localparam logic [OP_W-1:0] OP_OR      = 3'd2;
  localparam logic [OP_W-1:0] OP_NAME    = 3'd3;
  localparam logic [OP_W-1:0] OP_SETPOS  = 3'd4;
  localparam logic [OP_W-1:0] OP_FIND    = 3'd5;
  localparam logic [OP_W-1:0] OP_BIND    = 3'd6;
  localparam logic [OP_W-1:0] OP_READ    = 3'd7;

  localparam logic [ERR_W-1:0] ERR_OK       = 3'd0;
  localparam logic [ERR_W-1:0] ERR_EMPTY    = 3'd1;
  localparam logic [ERR_W-1:0] ERR_MISMATCH = 3'd2;
  localparam logic [ERR_W-1:0] ERR_FULL     = 3'd3;
  localparam logic [ERR_W-1:0] ERR_LEVEL    = 3'd4;

  localparam logic [MODE_W-1:0] FIND_FIRST  = 2'd0;
  localparam logic [MODE_W-1:0] FIND_NTH    = 2'd1;
  localparam logic [MODE_W-1:0] FIND_CLAUSE = 2'd2;
  localparam logic [MODE_W-1:0] FIND_NAME   = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]     operation;
    logic [KIND_W-1:0]   kind;
    logic [KIND_W-1:0]   second_kind;
    logic [KIND_W-1:0]   bound_kind;
    logic [MODE_W-1:0]   find_mode;
    logic [OCC_W-1:0]    occurrence;
    logic [CLAUSE_W-1:0] clause_mask;
    logic [NAME_W-1:0]   name_id;
    logic [LINE_W-1:0]   line_number;
    logic [FILE_W-1:0]   file_number;
    logic [LEVEL_W-1:0]  level;
  } in_t;

  typedef struct packed {
    logic [ERR_W-1:0]    error;
    logic                found;
    logic [INDEX_W-1:0]  index;
    logic                truth;
    logic [KIND_W-1:0]   entry_kind;
    logic [CLAUSE_W-1:0] entry_clauses;
    logic [LINE_W-1:0]   entry_line;
    logic [FILE_W-1:0]   entry_file;
    logic [NAME_W-1:0]   entry_name;
    logic                entry_named;
    logic [COUNT_W-1:0]  entries;
  } out_t;

  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_LATCH,
    ACT_PUSH,
    ACT_POP,
    ACT_RD_TOP,
    ACT_RD_LVL,
    ACT_SET_NAME,
    ACT_SET_POS,
    ACT_OR_WB,
    ACT_WALK_START,
    ACT_WALK
  } act_e;

  typedef enum logic [1:0] {
    RES_PLAIN,
    RES_ENTRY,
    RES_SEARCH
  } res_e;

  typedef struct packed {
    act_e             act;
    logic             finish;
    logic [ERR_W-1:0] err;
    res_e             res;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            empty;
    logic            full;
    logic            level_bad;
    logic            mismatch;
    logic            walk_last;
  } sts_t;

endpackage

>>> rtl/nsks_ctrl.sv
// controller state machine sequencing each transaction through the datapath
`timescale 1ns / 1ps

module nsks_ctrl
  import nsks_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ISSUE = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_WALK  = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       in_stall;

  assign in_stall = (state_q != S_IDLE) || (out_valid_q && out_stall_i);

  always_comb begin
    state_d = state_q;
    cmd_o   = '{act: ACT_NONE, finish: 1'b0, err: ERR_OK, res: RES_PLAIN};
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && !in_stall) begin
          cmd_o.act = ACT_LATCH;
          state_d   = S_ISSUE;
        end
      end
      S_ISSUE: begin
        state_d = S_IDLE;
        case (sts_i.op)
          OP_PUSH: begin
            cmd_o.finish = 1'b1;
            if (sts_i.full) begin
              cmd_o.err = ERR_FULL;
            end else begin
              cmd_o.act = ACT_PUSH;
            end
          end
          OP_POP, OP_OR: begin
            if (sts_i.empty) begin
              cmd_o.finish = 1'b1;
              cmd_o.err    = ERR_EMPTY;
            end else begin
              cmd_o.act = ACT_RD_TOP;
              state_d   = S_CHECK;
            end
          end
          OP_NAME: begin
            cmd_o.finish = 1'b1;
            if (sts_i.empty) begin
              cmd_o.err = ERR_EMPTY;
            end else begin
              cmd_o.act = ACT_SET_NAME;
            end
          end
          OP_SETPOS, OP_READ: begin
            if (sts_i.empty) begin
              cmd_o.finish = 1'b1;
              cmd_o.err    = ERR_EMPTY;
            end else if (sts_i.level_bad) begin
              cmd_o.finish = 1'b1;
              cmd_o.err    = ERR_LEVEL;
            end else if (sts_i.op == OP_SETPOS) begin
              cmd_o.finish = 1'b1;
              cmd_o.act    = ACT_SET_POS;
            end else begin
              cmd_o.act = ACT_RD_LVL;
              state_d   = S_CHECK;
            end
          end
          default: begin
            // find and bind check
            if (sts_i.empty) begin
              cmd_o.finish = 1'b1;
            end else begin
              cmd_o.act = ACT_WALK_START;
              state_d   = S_WALK;
            end
          end
        endcase
      end
      S_CHECK: begin
        state_d      = S_IDLE;
        cmd_o.finish = 1'b1;
        case (sts_i.op)
          OP_POP: begin
            if (sts_i.mismatch) begin
              cmd_o.err = ERR_MISMATCH;
            end else begin
              cmd_o.act = ACT_POP;
            end
          end
          OP_OR: begin
            cmd_o.act = ACT_OR_WB;
          end
          default: begin
            cmd_o.res = RES_ENTRY;
          end
        endcase
      end
      S_WALK: begin
        cmd_o.act = ACT_WALK;
        if (sts_i.walk_last) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        cmd_o.finish = 1'b1;
        cmd_o.res    = RES_SEARCH;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.finish) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = in_stall;
  assign out_valid_o = out_valid_q;

endmodule

>>> rtl/nsks_dp.sv
// datapath: entry memory, fill count, search walk trackers and result register
`timescale 1ns / 1ps

module nsks_dp
  import nsks_pkg::*;
#(
  parameter int STACK_DEPTH = 16,
  parameter int CLAUSE_BITS = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  in_t  in_data_i,
  input  cmd_t cmd_i,
  output sts_t sts_o,
  output out_t out_data_o
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int FW = $clog2(STACK_DEPTH + 1);
  localparam int LW = (FW > LEVEL_W) ? FW : LEVEL_W;
  localparam int MW = (CLAUSE_BITS < CLAUSE_W) ? CLAUSE_BITS : CLAUSE_W;

  // entry storage
  logic [KIND_W-1:0]      mem_kind   [STACK_DEPTH];
  logic [CLAUSE_BITS-1:0] mem_clause [STACK_DEPTH];
  logic [LINE_W-1:0]      mem_line   [STACK_DEPTH];
  logic [FILE_W-1:0]      mem_file   [STACK_DEPTH];
  logic [NAME_W-1:0]      mem_name   [STACK_DEPTH];
  logic                   mem_named  [STACK_DEPTH];

  logic [KIND_W-1:0]      rd_kind_q;
  logic [CLAUSE_BITS-1:0] rd_clause_q;
  logic [LINE_W-1:0]      rd_line_q;
  logic [FILE_W-1:0]      rd_file_q;
  logic [NAME_W-1:0]      rd_name_q;
  logic                   rd_named_q;

  in_t            item_q;
  logic [FW-1:0]  fill_q, fill_d;
  logic [AW-1:0]  pos_q;
  logic [OCC_W-1:0] hits_q;
  logic           n_found_q, f1_found_q, f2_found_q, f3_found_q;
  logic [AW-1:0]  n_pos_q, f1_pos_q, f2_pos_q, f3_pos_q;
  out_t           out_q;

  logic [AW-1:0]          top_addr, lvl_addr, rd_addr, wr_addr;
  logic                   we_kind, we_clause, we_pos, we_name;
  logic [CLAUSE_BITS-1:0] mask_cw, wr_clause;
  logic [CLAUSE_W-1:0]    ent_clause;
  logic                   clause_hit, is_bind, n_match, n_hit_now, bind_ok;
  logic [OCC_W-1:0]       nth;
  out_t                   res;

  assign top_addr = AW'(fill_q - FW'(1));
  assign lvl_addr = AW'(LW'(fill_q) - LW'(1) - LW'(item_q.level));

  always_comb begin
    mask_cw    = '0;
    ent_clause = '0;
    for (int i = 0; i < MW; i++) begin
      mask_cw[i]    = item_q.clause_mask[i];
      ent_clause[i] = rd_clause_q[i];
    end
  end

  assign clause_hit = |(rd_clause_q & mask_cw);

  // memory address and write control
  always_comb begin
    rd_addr   = top_addr;
    wr_addr   = top_addr;
    we_kind   = 1'b0;
    we_clause = 1'b0;
    we_pos    = 1'b0;
    we_name   = 1'b0;
    case (cmd_i.act)
      ACT_RD_LVL: rd_addr = lvl_addr;
      ACT_WALK:   rd_addr = pos_q - AW'(1);
      ACT_PUSH: begin
        wr_addr   = AW'(fill_q);
        we_kind   = 1'b1;
        we_clause = 1'b1;
        we_pos    = 1'b1;
        we_name   = 1'b1;
      end
      ACT_SET_NAME: we_name = 1'b1;
      ACT_SET_POS: begin
        wr_addr = lvl_addr;
        we_pos  = 1'b1;
      end
      ACT_OR_WB: we_clause = 1'b1;
      default: begin
        rd_addr = top_addr;
      end
    endcase
  end

  assign wr_clause = (cmd_i.act == ACT_PUSH) ? '0 : (rd_clause_q | mask_cw);

  always_ff @(posedge clk_i) begin
    if (we_kind) begin
      mem_kind[wr_addr] <= item_q.kind;
    end
    if (we_clause) begin
      mem_clause[wr_addr] <= wr_clause;
    end
    if (we_pos) begin
      mem_line[wr_addr] <= item_q.line_number;
      mem_file[wr_addr] <= item_q.file_number;
    end
    if (we_name) begin
      mem_name[wr_addr]  <= (cmd_i.act == ACT_PUSH) ? '0 : item_q.name_id;
      mem_named[wr_addr] <= (cmd_i.act != ACT_PUSH);
    end
    rd_kind_q   <= mem_kind[rd_addr];
    rd_clause_q <= mem_clause[rd_addr];
    rd_line_q   <= mem_line[rd_addr];
    rd_file_q   <= mem_file[rd_addr];
    rd_name_q   <= mem_name[rd_addr];
    rd_named_q  <= mem_named[rd_addr];
  end

  // fill count
  always_comb begin
    fill_d = fill_q;
    case (cmd_i.act)
      ACT_PUSH: fill_d = fill_q + FW'(1);
      ACT_POP:  fill_d = fill_q - FW'(1);
      default:  fill_d = fill_q;
    endcase
  end

  // search match for the current walk entry
  assign is_bind = (item_q.operation == OP_BIND);
  assign n_match = (rd_kind_q == item_q.kind) &&
                   (is_bind ||
                    ((item_q.find_mode != FIND_CLAUSE || clause_hit) &&
                     (item_q.find_mode != FIND_NAME ||
                      (rd_named_q && rd_name_q == item_q.name_id))));

  always_comb begin
    if (is_bind) begin
      nth = OCC_W'(2);
    end else if (item_q.find_mode == FIND_NTH) begin
      nth = item_q.occurrence;
    end else begin
      nth = OCC_W'(1);
    end
  end

  assign n_hit_now = n_match && !n_found_q && (nth != '0) &&
                     (({1'b0, hits_q} + (OCC_W + 1)'(1)) == {1'b0, nth});

  always_comb begin
    bind_ok = 1'b0;
    if (f1_found_q && f2_found_q && f3_found_q) begin
      if (f1_pos_q == f2_pos_q) begin
        bind_ok = n_found_q && (f3_pos_q < f2_pos_q) && (f3_pos_q < n_pos_q);
      end else begin
        bind_ok = (f3_pos_q < f1_pos_q) && (f3_pos_q < f2_pos_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q     <= '0;
      pos_q      <= '0;
      hits_q     <= '0;
      n_found_q  <= 1'b0;
      f1_found_q <= 1'b0;
      f2_found_q <= 1'b0;
      f3_found_q <= 1'b0;
      n_pos_q    <= '0;
      f1_pos_q   <= '0;
      f2_pos_q   <= '0;
      f3_pos_q   <= '0;
    end else begin
      fill_q <= fill_d;
      if (cmd_i.act == ACT_WALK_START) begin
        pos_q      <= top_addr;
        hits_q     <= '0;
        n_found_q  <= 1'b0;
        f1_found_q <= 1'b0;
        f2_found_q <= 1'b0;
        f3_found_q <= 1'b0;
      end else if (cmd_i.act == ACT_WALK) begin
        pos_q <= pos_q - AW'(1);
        if (n_match && !n_found_q) begin
          hits_q <= hits_q + OCC_W'(1);
        end
        if (n_hit_now) begin
          n_found_q <= 1'b1;
          n_pos_q   <= pos_q;
        end
        if (!f1_found_q && rd_kind_q == item_q.kind) begin
          f1_found_q <= 1'b1;
          f1_pos_q   <= pos_q;
        end
        if (!f2_found_q && rd_kind_q == item_q.second_kind) begin
          f2_found_q <= 1'b1;
          f2_pos_q   <= pos_q;
        end
        if (!f3_found_q && rd_kind_q == item_q.bound_kind) begin
          f3_found_q <= 1'b1;
          f3_pos_q   <= pos_q;
        end
      end
    end
  end

  // result assembly
  always_comb begin
    res         = '0;
    res.error   = cmd_i.err;
    res.entries = COUNT_W'(fill_d);
    case (cmd_i.res)
      RES_ENTRY: begin
        res.truth         = clause_hit;
        res.entry_kind    = rd_kind_q;
        res.entry_clauses = ent_clause;
        res.entry_line    = rd_line_q;
        res.entry_file    = rd_file_q;
        res.entry_name    = rd_name_q;
        res.entry_named   = rd_named_q;
      end
      RES_SEARCH: begin
        if (is_bind) begin
          res.truth = bind_ok;
        end else if (n_found_q) begin
          res.found = 1'b1;
          res.index = INDEX_W'(n_pos_q);
        end
      end
      default: begin
        res.truth = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.act == ACT_LATCH) begin
      item_q <= in_data_i;
    end
    if (cmd_i.finish) begin
      out_q <= res;
    end
  end

  assign sts_o.op        = item_q.operation;
  assign sts_o.empty     = (fill_q == '0);
  assign sts_o.full      = (fill_q == FW'(STACK_DEPTH));
  assign sts_o.level_bad = (LW'(item_q.level) >= LW'(fill_q));
  assign sts_o.mismatch  = (rd_kind_q != item_q.kind);
  assign sts_o.walk_last = (pos_q == '0);

  assign out_data_o = out_q;

endmodule

>>> rtl/nesting_stack_with_kind_search.sv
// top level: bounded nesting stack with kind search, controller plus datapath
// finish in the issue state: push, set name, set position, errors caught at issue, and find
// or bind check on an empty stack; finish in the check state: pop, kind mismatch included, or
// clauses and read; find and bind check on a non-empty stack walk every entry, reading one a
// cycle, then finish; a new transaction is taken only when idle and the result is not stalled
// reset clears the fill count and handshake state; entry memory is not cleared
`timescale 1ns / 1ps

module nesting_stack_with_kind_search
  import nsks_pkg::*;
#(
  parameter int STACK_DEPTH = 16,
  parameter int CLAUSE_BITS = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  cmd_t cmd;
  sts_t sts;

  nsks_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  nsks_dp #(
    .STACK_DEPTH (STACK_DEPTH),
    .CLAUSE_BITS (CLAUSE_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule
